// ----- sv/pileup_consensus_caller_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the pileup consensus caller.
// The checks compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PILEUP_CONSENSUS_CALLER_DEFINES_SVH
`define PILEUP_CONSENSUS_CALLER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define PCC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("pileup_consensus_caller: same-cycle check failed");
// Next-cycle implication check.
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("pileup_consensus_caller: next-cycle check failed");
`else
`define PCC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/pcc_pkg.sv -----
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared codes, queue entry and configuration types of the consensus caller.
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

	// Input actions.
	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_ADD    = 2'd1,
		ACT_FINISH = 2'd2,
		ACT_NONE   = 2'd3
	} pcc_action_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_MODE       = 2'd0,
		REG_GAP_PCT    = 2'd1,
		REG_MIN_SCORE  = 2'd2,
		REG_MIN_MARGIN = 2'd3
	} pcc_reg_t;

	// Base and call codes.
	localparam logic [2:0] CODE_A   = 3'd0;
	localparam logic [2:0] CODE_C   = 3'd1;
	localparam logic [2:0] CODE_G   = 3'd2;
	localparam logic [2:0] CODE_T   = 3'd3;
	localparam logic [2:0] CODE_N   = 3'd4;
	localparam logic [2:0] CODE_GAP = 3'd5;

	// Matrix column used by symbols other than A, C, G, T.
	localparam logic [2:0] COL_OTHER = 3'd4;
	localparam int         NCOLS     = 5;

	localparam logic [1:0] MODE_MARGIN = 2'd2;
	localparam logic [6:0] GAP_SCALE   = 7'd100;

	// Queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef enum logic {
		OP_ADD    = 1'b0,
		OP_FINISH = 1'b1
	} pcc_op_t;

	typedef struct packed {
		pcc_op_t     op;
		logic [2:0]  code;
		logic        use_row;
		logic [63:0] row;
	} pcc_qent_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [6:0]         gap_pct;
		logic signed [31:0] min_score;
		logic signed [31:0] min_margin;
	} pcc_cfg_t;

endpackage

`default_nettype wire

// ----- sv/pcc_in_if.sv -----
// ----------------------------------------------------------------------------
// pcc_in_if
// Input channel: one load, add or finish item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [2:0]  base_code;
	logic        reverse_strand;
	logic [4:0]  depth_index;
	logic [63:0] matrix_word;

	modport source (
		output valid, action, base_code, reverse_strand, depth_index, matrix_word,
		input  ready
	);
	modport sink (
		input  valid, action, base_code, reverse_strand, depth_index, matrix_word,
		output ready
	);
endinterface

`default_nettype wire

// ----- sv/pcc_out_if.sv -----
// ----------------------------------------------------------------------------
// pcc_out_if
// Output channel: one consensus call per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcc_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  consensus_code;
	logic [15:0] agree_count;
	logic [15:0] coverage;

	modport source (
		output valid, consensus_code, agree_count, coverage,
		input  ready
	);
	modport sink (
		input  valid, consensus_code, agree_count, coverage,
		output ready
	);
endinterface

`default_nettype wire

// ----- sv/pcc_front.sv -----
// ----------------------------------------------------------------------------
// pcc_front
// Accepts items, writes matrix rows, reads the row of each added base and
// queues add and finish work for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_front #(
	parameter int MATRIX_DEPTH = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	pcc_in_if.sink                         bases,
	input  wire logic [pcc_pkg::QCNT_W-1:0] q_count,
	output logic                           push,
	output pcc_pkg::pcc_qent_t             push_ent
);
	import pcc_pkg::*;

	localparam int ROWS  = 2 * MATRIX_DEPTH * NCOLS;
	localparam int ROW_W = $clog2(ROWS);

	logic [63:0]      mem [ROWS];
	logic             accept;
	logic             is_load;
	logic             is_add;
	logic             is_fin;
	logic             depth_ok;
	logic [2:0]       col;
	logic [ROW_W-1:0] row_idx;
	logic             use_row;

	logic             v_s1;
	pcc_op_t          op_s1;
	logic [2:0]       code_s1;
	logic             use_row_s1;
	logic [63:0]      row_s1;

	// Hold off while the queue plus the item in flight would overfill it.
	assign bases.ready = (q_count + QCNT_W'(v_s1)) < QCNT_W'(QDEPTH);
	assign accept      = bases.valid && bases.ready;

	always_comb begin
		is_load  = bases.action == ACT_LOAD;
		is_add   = bases.action == ACT_ADD;
		is_fin   = bases.action == ACT_FINISH;
		depth_ok = 32'(bases.depth_index) < 32'(MATRIX_DEPTH);
		col      = (bases.base_code < COL_OTHER) ? bases.base_code : COL_OTHER;
		if (is_load) begin
			col = bases.base_code;
		end
		row_idx  = ROW_W'((32'(bases.reverse_strand) * 32'(MATRIX_DEPTH)
			+ 32'(bases.depth_index)) * 32'(NCOLS) + 32'(col));
		use_row  = depth_ok && (bases.base_code != CODE_GAP);
	end

	always_ff @(posedge clk) begin
		if (accept && is_load && depth_ok && (bases.base_code <= COL_OTHER)) begin
			mem[row_idx] <= bases.matrix_word;
		end
		if (accept && is_add && use_row) begin
			row_s1 <= mem[row_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept && (is_add || is_fin);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= is_fin ? OP_FINISH : OP_ADD;
			code_s1    <= bases.base_code;
			use_row_s1 <= use_row;
		end
	end

	assign push             = v_s1;
	assign push_ent.op      = op_s1;
	assign push_ent.code    = code_s1;
	assign push_ent.use_row = use_row_s1;
	assign push_ent.row     = row_s1;

endmodule

`default_nettype wire

// ----- sv/pcc_fifo.sv -----
// ----------------------------------------------------------------------------
// pcc_fifo
// Short work queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_fifo (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire pcc_pkg::pcc_qent_t         push_ent,
	input  wire logic                       pop,
	output pcc_pkg::pcc_qent_t              head,
	output logic                            head_valid,
	output logic [pcc_pkg::QCNT_W-1:0]      count
);
	import pcc_pkg::*;

	pcc_qent_t         ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	assign head       = ent_q[rd_ptr_q];
	assign head_valid = count_q != '0;
	assign count      = count_q;

endmodule

`default_nettype wire

// ----- sv/pcc_back.sv -----
// ----------------------------------------------------------------------------
// pcc_back
// Column accumulator: saturating counts and score sums, cleared on finish.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_back #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire pcc_pkg::pcc_qent_t          head,
	input  wire logic                        head_valid,
	output logic                             pop,
	output logic                             fin_valid,
	input  wire logic                        fin_ready,
	output logic [3:0][COUNT_BITS-1:0]       snap_base,
	output logic [COUNT_BITS-1:0]            snap_gap,
	output logic [COUNT_BITS-1:0]            snap_cov,
	output logic [3:0][31:0]                 snap_sum
);
	import pcc_pkg::*;

	logic [3:0][COUNT_BITS-1:0] base_q;
	logic [COUNT_BITS-1:0]      gap_q;
	logic [COUNT_BITS-1:0]      cov_q;
	logic [3:0][31:0]           sum_q;
	logic                       do_add;
	logic                       do_clr;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		sat_inc = (&v) ? v : v + COUNT_BITS'(1);
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
		logic [32:0] s;
		s = {a[31], a} + {{17{b[15]}}, b};
		if (s[32] != s[31]) begin
			sat_add = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			sat_add = s[31:0];
		end
	endfunction

	always_comb begin
		fin_valid = head_valid && (head.op == OP_FINISH);
		do_add    = head_valid && (head.op == OP_ADD);
		do_clr    = fin_valid && fin_ready;
		pop       = do_add || do_clr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			gap_q  <= '0;
			cov_q  <= '0;
			sum_q  <= '0;
		end else if (do_clr) begin
			base_q <= '0;
			gap_q  <= '0;
			cov_q  <= '0;
			sum_q  <= '0;
		end else if (do_add) begin
			for (int k = 0; k < 4; k++) begin
				if (head.code == 3'(k)) begin
					base_q[k] <= sat_inc(base_q[k]);
				end
				if (head.use_row) begin
					sum_q[k] <= sat_add(sum_q[k], head.row[16*k +: 16]);
				end
			end
			if (head.code == CODE_GAP) begin
				gap_q <= sat_inc(gap_q);
			end
			cov_q <= sat_inc(cov_q);
		end
	end

	assign snap_base = base_q;
	assign snap_gap  = gap_q;
	assign snap_cov  = cov_q;
	assign snap_sum  = sum_q;

endmodule

`default_nettype wire

// ----- sv/pcc_decide.sv -----
// ----------------------------------------------------------------------------
// pcc_decide
// Call pipeline: column snapshot, gap test and pairwise ranking, final ranking,
// acceptance rule and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_decide #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire pcc_pkg::pcc_cfg_t            cfg,
	input  wire logic                         fin_valid,
	output logic                              fin_ready,
	input  wire logic [3:0][COUNT_BITS-1:0]   snap_base,
	input  wire logic [COUNT_BITS-1:0]        snap_gap,
	input  wire logic [COUNT_BITS-1:0]        snap_cov,
	input  wire logic [3:0][31:0]             snap_sum,
	pcc_out_if.source                         calls
);
	import pcc_pkg::*;

	localparam int PW = COUNT_BITS + 7;

	function automatic logic [15:0] clamp16(input logic [COUNT_BITS-1:0] v);
		clamp16 = (32'(v) > 32'h0000_FFFF) ? 16'hFFFF : 16'(v);
	endfunction

	// Stage enables: a stage loads when empty or when it drains.
	logic en_s1, en_s2, en_s3, en_out;
	logic v_s1, v_s2, v_s3, out_v_q;

	// Stage 1: column snapshot.
	logic [3:0][COUNT_BITS-1:0] cnt_s1;
	logic [COUNT_BITS-1:0]      gap_s1;
	logic [COUNT_BITS-1:0]      cov_s1;
	logic signed [31:0]         sum_s1 [4];

	// Stage 2: gap test and pair winners.
	logic [3:0][COUNT_BITS-1:0] cnt_s2;
	logic [COUNT_BITS-1:0]      gap_s2;
	logic [COUNT_BITS-1:0]      cov_s2;
	logic                       zero_s2;
	logic                       gap_hit_s2;
	logic signed [31:0]         hi_a_s2, lo_a_s2, hi_b_s2, lo_b_s2;
	logic [1:0]                 idx_a_s2, idx_b_s2;

	// Stage 3: ranked scores and preliminary call.
	logic [2:0]                 call_s3;
	logic                       is_base_s3;
	logic signed [31:0]         top_s3, second_s3;
	logic [15:0]                agree_s3, cov_s3;

	// Output register.
	logic [2:0]                 code_q;
	logic [15:0]                agree_q, cov_q;

	// Stage 1 combinational.
	logic [PW-1:0]              gap_lhs, gap_rhs;
	logic                       take_1, take_3;
	// Stage 2 combinational.
	logic                       take_b;
	logic signed [31:0]         top_c, second_c;
	logic [1:0]                 best_c;
	logic [COUNT_BITS-1:0]      agree_c;
	logic [2:0]                 call_c;
	// Stage 3 combinational.
	logic signed [32:0]         lead;
	logic                       ok;

	always_comb begin
		en_out    = !out_v_q || calls.ready;
		en_s3     = !v_s3 || en_out;
		en_s2     = !v_s2 || en_s3;
		en_s1     = !v_s1 || en_s2;
		fin_ready = en_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= fin_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_out) begin
				out_v_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && fin_valid) begin
			cnt_s1 <= snap_base;
			gap_s1 <= snap_gap;
			cov_s1 <= snap_cov;
			for (int k = 0; k < 4; k++) begin
				sum_s1[k] <= $signed(snap_sum[k]);
			end
		end
	end

	always_comb begin
		gap_lhs = PW'(gap_s1) * PW'(GAP_SCALE);
		gap_rhs = PW'(cfg.gap_pct) * PW'(cov_s1);
		take_1  = sum_s1[1] >= sum_s1[0];
		take_3  = sum_s1[3] >= sum_s1[2];
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			cnt_s2     <= cnt_s1;
			gap_s2     <= gap_s1;
			cov_s2     <= cov_s1;
			zero_s2    <= cov_s1 == '0;
			gap_hit_s2 <= gap_lhs >= gap_rhs;
			hi_a_s2    <= take_1 ? sum_s1[1] : sum_s1[0];
			lo_a_s2    <= take_1 ? sum_s1[0] : sum_s1[1];
			idx_a_s2   <= take_1 ? 2'(CODE_C) : 2'(CODE_A);
			hi_b_s2    <= take_3 ? sum_s1[3] : sum_s1[2];
			lo_b_s2    <= take_3 ? sum_s1[2] : sum_s1[3];
			idx_b_s2   <= take_3 ? 2'(CODE_T) : 2'(CODE_G);
		end
	end

	// Later base wins a tie, so the upper pair takes equal maxima.
	always_comb begin
		take_b = hi_b_s2 >= hi_a_s2;
		if (take_b) begin
			top_c    = hi_b_s2;
			second_c = (lo_b_s2 >= hi_a_s2) ? lo_b_s2 : hi_a_s2;
			best_c   = idx_b_s2;
		end else begin
			top_c    = hi_a_s2;
			second_c = (lo_a_s2 >= hi_b_s2) ? lo_a_s2 : hi_b_s2;
			best_c   = idx_a_s2;
		end
		if (zero_s2) begin
			agree_c = '0;
			call_c  = CODE_N;
		end else if (gap_hit_s2) begin
			agree_c = gap_s2;
			call_c  = CODE_GAP;
		end else begin
			agree_c = cnt_s2[best_c];
			call_c  = {1'b0, best_c};
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			call_s3    <= call_c;
			is_base_s3 <= !zero_s2 && !gap_hit_s2;
			top_s3     <= top_c;
			second_s3  <= second_c;
			agree_s3   <= clamp16(agree_c);
			cov_s3     <= clamp16(cov_s2);
		end
	end

	always_comb begin
		lead = $signed({top_s3[31], top_s3}) - $signed({cfg.min_margin[31], cfg.min_margin});
		if (cfg.mode == MODE_MARGIN) begin
			ok = !top_s3[31] || (lead > $signed({second_s3[31], second_s3}));
		end else begin
			ok = top_s3 >= cfg.min_score;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s3) begin
			code_q  <= (is_base_s3 && !ok) ? CODE_N : call_s3;
			agree_q <= agree_s3;
			cov_q   <= cov_s3;
		end
	end

	assign calls.valid          = out_v_q;
	assign calls.consensus_code = code_q;
	assign calls.agree_count    = agree_q;
	assign calls.coverage       = cov_q;

endmodule

`default_nettype wire

// ----- sv/pileup_consensus_caller.sv -----
// ----------------------------------------------------------------------------
// pileup_consensus_caller: a finish passes the front register, queue and call
// pipeline; one item per cycle while ready is high, bounded by the single matrix
// port. arst_n clears config (mode 1, gap 50%, thresholds 0), counts and sums.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pileup_consensus_caller_defines.svh"

module pileup_consensus_caller #(
	parameter int MATRIX_DEPTH = 32,
	parameter int COUNT_BITS   = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire pcc_pkg::pcc_reg_t cfg_index,
	input  wire logic [31:0]       cfg_wdata,
	pcc_in_if.sink                 bases,
	pcc_out_if.source              calls
);
	import pcc_pkg::*;

	// Configuration registers. Users must write them only while the block is idle
	// (the block does not enforce this), as the call pipeline reads them directly.
	logic [1:0]         mode_q;
	logic [6:0]         gap_pct_q;
	logic signed [31:0] min_score_q;
	logic signed [31:0] min_margin_q;
	pcc_cfg_t           cfg;

	// Front to queue.
	logic               q_push;
	pcc_qent_t          q_push_ent;
	// Queue to back.
	pcc_qent_t          q_head;
	logic               q_head_valid;
	logic               q_pop;
	logic [QCNT_W-1:0]  q_count;

	// Back to call pipeline.
	logic                       fin_valid;
	logic                       fin_ready;
	logic [3:0][COUNT_BITS-1:0] snap_base;
	logic [COUNT_BITS-1:0]      snap_gap;
	logic [COUNT_BITS-1:0]      snap_cov;
	logic [3:0][31:0]           snap_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 2'd1;
			gap_pct_q    <= 7'd50;
			min_score_q  <= '0;
			min_margin_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:       mode_q       <= cfg_wdata[1:0];
				REG_GAP_PCT:    gap_pct_q    <= cfg_wdata[6:0];
				REG_MIN_SCORE:  min_score_q  <= $signed(cfg_wdata);
				REG_MIN_MARGIN: min_margin_q <= $signed(cfg_wdata);
				default:        mode_q       <= mode_q;
			endcase
		end
	end

	always_comb begin
		cfg.mode       = mode_q;
		cfg.gap_pct    = gap_pct_q;
		cfg.min_score  = min_score_q;
		cfg.min_margin = min_margin_q;
	end

	// Front: take items, write matrix rows, look up the row of each added
	// base, drop loads and unused actions, push add and finish work.
	pcc_front #(
		.MATRIX_DEPTH (MATRIX_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.bases    (bases),
		.q_count  (q_count),
		.push     (q_push),
		.push_ent (q_push_ent)
	);

	// Queue: lets the front keep taking items while a finish waits on a
	// stalled call pipeline.
	pcc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_ent   (q_push_ent),
		.pop        (q_pop),
		.head       (q_head),
		.head_valid (q_head_valid),
		.count      (q_count)
	);

	// Back: advance the column state one add per cycle; a finish hands the
	// column over and clears it in the same cycle.
	pcc_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.head_valid (q_head_valid),
		.pop        (q_pop),
		.fin_valid  (fin_valid),
		.fin_ready  (fin_ready),
		.snap_base  (snap_base),
		.snap_gap   (snap_gap),
		.snap_cov   (snap_cov),
		.snap_sum   (snap_sum)
	);

	// Call pipeline: snapshot, gap test and pair ranking, final ranking, acceptance
	// rule, then the output register that holds a call until taken.
	pcc_decide #(
		.COUNT_BITS (COUNT_BITS)
	) u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready),
		.snap_base (snap_base),
		.snap_gap  (snap_gap),
		.snap_cov  (snap_cov),
		.snap_sum  (snap_sum),
		.calls     (calls)
	);

	// A full queue must never see a push.
	`PCC_ASSERT_IMPLY(a_no_overflow, clk, arst_n, q_count == QCNT_W'(QDEPTH), !q_push)
	// The back end never pops an empty queue.
	`PCC_ASSERT_IMPLY(a_no_underflow, clk, arst_n, q_pop, q_count != '0)
	// Agreeing reads are a subset of the column's reads.
	`PCC_ASSERT_IMPLY(a_agree_le_cov, clk, arst_n, calls.valid,
		calls.agree_count <= calls.coverage)
	// A finish handed to the call pipeline leaves an empty column behind.
	`PCC_ASSERT_NEXT(a_column_cleared, clk, arst_n, fin_valid && fin_ready,
		snap_cov == '0)

endmodule

`default_nettype wire
